// ----- sv/rmg_pkg.sv -----
// Shared types, register indexes and arithmetic helpers of the revolution mesh generator
`default_nettype none
package rmg_pkg;

    localparam int COORD_W   = 24;
    localparam int TRIG_W    = 16;
    localparam int TRIG_FRAC = 14;
    localparam int NORM_W    = 48;
    localparam int COL_W     = 6;
    localparam int STEPS_W   = 7;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int ROT_W     = COORD_W + TRIG_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_STEPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_STEP   = 2'd2;

    localparam logic [STEPS_W-1:0]       RESET_RING_STEPS = 7'd32;
    localparam logic signed [TRIG_W-1:0] RESET_COS_STEP   = 16'sd16069;
    localparam logic signed [TRIG_W-1:0] RESET_SIN_STEP   = 16'sd3196;

    typedef struct packed {
        logic signed [COORD_W-1:0] profile_radius;
        logic signed [COORD_W-1:0] profile_height;
        logic                      new_profile;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic [COL_W-1:0]          column;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic                      normal_valid;
        logic                      last_in_ring;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vtx;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic load_first;
        logic prep;
        logic sum;
        logic advance;
        logic last;
    } t_cmd;

    // round half up, floor shift by the trig fraction, saturate to a coordinate
    function automatic logic signed [COORD_W-1:0] rot_round_sat(
        input logic signed [ROT_W:0] p
    );
        logic signed [ROT_W:0] t;
        t = (p + (ROT_W+1)'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        if (t > (ROT_W+1)'(8388607))
            return 24'sh7FFFFF;
        else if (t < -(ROT_W+1)'(8388608))
            return 24'sh800000;
        else
            return t[COORD_W-1:0];
    endfunction

    function automatic logic signed [NORM_W-1:0] norm_sat(
        input logic signed [PROD_W:0] v
    );
        if (v > (PROD_W+1)'(48'sh7FFF_FFFF_FFFF))
            return 48'sh7FFF_FFFF_FFFF;
        else if (v < -(PROD_W+1)'(49'sh0_8000_0000_0000))
            return 48'sh8000_0000_0000;
        else
            return v[NORM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/rmg_ctrl.sv -----
// Column sequencer of the revolution mesh generator
`default_nettype none
module rmg_ctrl #(
    parameter int MAX_RING_STEPS = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    input  wire  [$clog2(MAX_RING_STEPS+1)-1:0]    i_ring_n,
    output rmg_pkg::t_cmd                          o_cmd,
    output logic [$clog2(MAX_RING_STEPS)-1:0]      o_col,
    output logic [$clog2(MAX_RING_STEPS)-1:0]      o_rd_addr
);
    localparam int IDX_W = $clog2(MAX_RING_STEPS);
    localparam int CNT_W = $clog2(MAX_RING_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH0, S_ROT, S_PREP, S_DIFF, S_MUL, S_SUM, S_OUT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_col;
    logic             last;
    logic [IDX_W-1:0] next_col;
    logic             start;

    assign last     = (CNT_W'(r_col) + CNT_W'(1)) == i_ring_n;
    assign next_col = last ? '0 : IDX_W'(r_col + IDX_W'(1));
    assign start    = (r_state == S_IDLE) && i_in_valid && (i_ring_n != '0);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_col       = r_col;
    assign o_rd_addr   = (r_state == S_FETCH0) ? '0 : next_col;

    always_comb begin
        o_cmd            = '0;
        o_cmd.start      = start;
        o_cmd.load_first = (r_state == S_ROT) && (r_col == '0);
        o_cmd.prep       = (r_state == S_PREP);
        o_cmd.sum        = (r_state == S_SUM);
        o_cmd.advance    = (r_state == S_OUT) && i_out_ready && !last;
        o_cmd.last       = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_col <= '0;
                    if (start) r_state <= S_FETCH0;
                end
                S_FETCH0: r_state <= S_ROT;
                S_ROT:    r_state <= S_PREP;
                S_PREP:   r_state <= S_DIFF;
                S_DIFF:   r_state <= S_MUL;
                S_MUL:    r_state <= S_SUM;
                S_SUM:    r_state <= S_OUT;
                S_OUT: begin
                    if (i_out_ready) begin
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= next_col;
                            r_state <= S_ROT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/rmg_datapath.sv -----
// Rotation, ring store and quad normal datapath of the revolution mesh generator
`default_nettype none
module rmg_datapath #(
    parameter int MAX_RING_STEPS = 64
) (
    input  wire                                           i_clk,
    input  wire                                           i_rst_n,
    input  wire                                           i_cfg_valid,
    input  wire  [rmg_pkg::CFG_IDX_W-1:0]                 i_cfg_index,
    input  wire  [rmg_pkg::CFG_DATA_W-1:0]                i_cfg_data,
    input  rmg_pkg::t_in                                  i_in_data,
    input  rmg_pkg::t_cmd                                 i_cmd,
    input  wire  [$clog2(MAX_RING_STEPS)-1:0]             i_col,
    input  wire  [$clog2(MAX_RING_STEPS)-1:0]             i_rd_addr,
    output logic [$clog2(MAX_RING_STEPS+1)-1:0]           o_ring_n,
    output rmg_pkg::t_out                                 o_out_data
);
    localparam int CNT_W  = $clog2(MAX_RING_STEPS + 1);
    localparam int CW     = rmg_pkg::COORD_W;
    localparam int DW     = rmg_pkg::DIFF_W;
    localparam int PW     = rmg_pkg::PROD_W;
    localparam int RW     = rmg_pkg::ROT_W;

    logic [rmg_pkg::STEPS_W-1:0]       r_ring_steps;
    logic signed [rmg_pkg::TRIG_W-1:0] r_cos;
    logic signed [rmg_pkg::TRIG_W-1:0] r_sin;
    logic [1:0]                        r_rings_seen;
    logic [1:0]                        r_seen;
    logic [1:0]                        seen_in;

    rmg_pkg::t_vtx r_mem [MAX_RING_STEPS];
    rmg_pkg::t_vtx r_rdata;
    rmg_pkg::t_vtx r_v1, r_v4, r_p0;
    logic signed [CW-1:0] r_x0, r_y0, r_z, r_cx, r_cy, r_v3x, r_v3y;
    logic signed [RW-1:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [DW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [PW-1:0] r_m [6];
    rmg_pkg::t_out        r_out;

    logic signed [DW-1:0] v1x, v1y, v1z, v2x, v2y, v3x, v3y, v4x, v4y, v4z, zz;

    assign o_ring_n = (r_ring_steps > rmg_pkg::STEPS_W'(MAX_RING_STEPS))
                    ? CNT_W'(MAX_RING_STEPS) : CNT_W'(r_ring_steps);
    assign seen_in  = i_in_data.new_profile ? 2'd0 : r_rings_seen;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_steps <= rmg_pkg::RESET_RING_STEPS;
            r_cos        <= rmg_pkg::RESET_COS_STEP;
            r_sin        <= rmg_pkg::RESET_SIN_STEP;
            r_rings_seen <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rmg_pkg::CFG_RING_STEPS: r_ring_steps <= i_cfg_data[rmg_pkg::STEPS_W-1:0];
                    rmg_pkg::CFG_COS_STEP:   r_cos        <= i_cfg_data;
                    rmg_pkg::CFG_SIN_STEP:   r_sin        <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start) r_rings_seen <= (seen_in == 2'd2) ? 2'd2 : seen_in + 2'd1;
        end
    end

    // previous ring store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) r_mem[i_col] <= '{x: r_cx, y: r_cy, z: r_z};
        r_rdata <= r_mem[i_rd_addr];
    end

    assign v1x = DW'(r_v1.x);
    assign v1y = DW'(r_v1.y);
    assign v1z = DW'(r_v1.z);
    assign v2x = DW'(r_cx);
    assign v2y = DW'(r_cy);
    assign v3x = DW'(r_v3x);
    assign v3y = DW'(r_v3y);
    assign v4x = DW'(r_v4.x);
    assign v4y = DW'(r_v4.y);
    assign v4z = DW'(r_v4.z);
    assign zz  = DW'(r_z);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x0   <= i_in_data.profile_radius;
            r_y0   <= '0;
            r_z    <= i_in_data.profile_height;
            r_cx   <= i_in_data.profile_radius;
            r_cy   <= '0;
            r_seen <= seen_in;
        end
        if (i_cmd.load_first) begin
            r_p0 <= r_rdata;
            r_v1 <= r_rdata;
        end

        r_pxc <= r_cx * r_cos;
        r_pys <= r_cy * r_sin;
        r_pxs <= r_cx * r_sin;
        r_pyc <= r_cy * r_cos;

        // next column and the far side of the quad; wrap to column 0 on the last one
        if (i_cmd.prep) begin
            if (i_cmd.last) begin
                r_v4  <= r_p0;
                r_v3x <= r_x0;
                r_v3y <= r_y0;
            end else begin
                r_v4  <= r_rdata;
                r_v3x <= rmg_pkg::rot_round_sat((RW+1)'(r_pxc) - (RW+1)'(r_pys));
                r_v3y <= rmg_pkg::rot_round_sat((RW+1)'(r_pxs) + (RW+1)'(r_pyc));
            end
        end

        if (r_seen == 2'd1) begin
            r_ax <= v2x - v1x;  r_ay <= v2y - v1y;  r_az <= zz - v1z;
            r_bx <= v3x - v1x;  r_by <= v3y - v1y;  r_bz <= zz - v1z;
        end else begin
            r_ax <= v4x - v3x;  r_ay <= v4y - v3y;  r_az <= v4z - zz;
            r_bx <= v1x - v3x;  r_by <= v1y - v3y;  r_bz <= v1z - zz;
        end

        r_m[0] <= r_by * r_az;
        r_m[1] <= r_ay * r_bz;
        r_m[2] <= r_bz * r_ax;
        r_m[3] <= r_az * r_bx;
        r_m[4] <= r_bx * r_ay;
        r_m[5] <= r_ax * r_by;

        if (i_cmd.sum) begin
            r_out.vertex_x     <= r_cx;
            r_out.vertex_y     <= r_cy;
            r_out.vertex_z     <= r_z;
            r_out.column       <= rmg_pkg::COL_W'(i_col);
            r_out.normal_valid <= (r_seen != 2'd0);
            r_out.last_in_ring <= i_cmd.last;
            if (r_seen == 2'd0) begin
                r_out.normal_x <= '0;
                r_out.normal_y <= '0;
                r_out.normal_z <= '0;
            end else begin
                r_out.normal_x <= rmg_pkg::norm_sat((PW+1)'(r_m[0]) - (PW+1)'(r_m[1]));
                r_out.normal_y <= rmg_pkg::norm_sat((PW+1)'(r_m[2]) - (PW+1)'(r_m[3]));
                r_out.normal_z <= rmg_pkg::norm_sat((PW+1)'(r_m[4]) - (PW+1)'(r_m[5]));
            end
        end

        // step to the next column
        if (i_cmd.advance) begin
            r_cx <= r_v3x;
            r_cy <= r_v3y;
            r_v1 <= r_v4;
        end
    end
endmodule
`default_nettype wire

// ----- sv/revolution_mesh_generator.sv -----
// Revolution mesh generator: one profile point in, one ring of vertices and normals out.
// Each column steps through rotation multiply, round, difference, normal multiply, sum and
// output, and the output beat waits for the receiver; all n columns of a point are done
// before the next point is taken. The sequencer is the limit.
// A point is taken only while no column is pending. Reset is synchronous, active low; it
// restores the register defaults and the quad row count, the ring store is left as it is.
`default_nettype none
module revolution_mesh_generator #(
    parameter int MAX_RING_STEPS = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [rmg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rmg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  rmg_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output rmg_pkg::t_out                      o_out_data
);
    localparam int IDX_W = $clog2(MAX_RING_STEPS);
    localparam int CNT_W = $clog2(MAX_RING_STEPS + 1);

    rmg_pkg::t_cmd    cmd;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] ring_n;

    assign o_cfg_ready = 1'b1;

    rmg_ctrl #(.MAX_RING_STEPS(MAX_RING_STEPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_ring_n    (ring_n),
        .o_cmd       (cmd),
        .o_col       (col),
        .o_rd_addr   (rd_addr)
    );

    rmg_datapath #(.MAX_RING_STEPS(MAX_RING_STEPS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_col       (col),
        .i_rd_addr   (rd_addr),
        .o_ring_n    (ring_n),
        .o_out_data  (o_out_data)
    );

    // the final beat of a ring ends the point
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last_in_ring |=> !o_out_valid && o_in_ready)
        else $error("beat after last column");

    // no point is taken while a column is pending
    a_idle_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready with pending beat");

    // without a quad the normal is zero
    a_no_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.normal_valid |->
            o_out_data.normal_x == '0 && o_out_data.normal_y == '0
            && o_out_data.normal_z == '0)
        else $error("normal without quad");
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the revolution mesh generator: ring and normal prediction with beat checks
`timescale 1ns / 1ps
module tb;

    class ring_scoreboard;
        int unsigned   steps;
        longint        cos_q, sin_q;
        rmg_pkg::t_vtx prev_ring [64];
        int unsigned   rows_seen;
        rmg_pkg::t_out expected_beats [$];
        int unsigned   errors;

        function new();
            steps = 32'(rmg_pkg::RESET_RING_STEPS);
            cos_q = rmg_pkg::RESET_COS_STEP;
            sin_q = rmg_pkg::RESET_SIN_STEP;
            rows_seen = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [rmg_pkg::CFG_IDX_W-1:0] idx,
                                logic [rmg_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                rmg_pkg::CFG_RING_STEPS: steps = 32'(val[rmg_pkg::STEPS_W-1:0]);
                rmg_pkg::CFG_COS_STEP:   cos_q = 64'($signed(val));
                rmg_pkg::CFG_SIN_STEP:   sin_q = 64'($signed(val));
                default: ;
            endcase
        endfunction

        function longint clip(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint rotate_round(longint p);
            return clip((p + 8192) >>> rmg_pkg::TRIG_FRAC, rmg_pkg::COORD_W);
        endfunction

        // negated cross product a x b, clipped to the normal width
        function void neg_cross(longint ax, longint ay, longint az, longint bx, longint by,
                                longint bz, output longint nx, output longint ny,
                                output longint nz);
            nx = clip(-(ay * bz - by * az), rmg_pkg::NORM_W);
            ny = clip(-(az * bx - bz * ax), rmg_pkg::NORM_W);
            nz = clip(-(ax * by - bx * ay), rmg_pkg::NORM_W);
        endfunction

        function void note_point(rmg_pkg::t_in pt);
            longint cx [64], cy [64], cz [64];
            longint nx, ny, nz;
            longint x1, y1, z1, x3, y3, z3, x4, y4, z4;
            int unsigned n, seen, b, nb;
            rmg_pkg::t_out o;
            n = steps > 64 ? 64 : steps;
            if (n == 0) return;
            seen = pt.new_profile ? 0 : rows_seen;
            cx[0] = 64'(pt.profile_radius);
            cy[0] = 0;
            cz[0] = 64'(pt.profile_height);
            for (b = 1; b < n; b++) begin
                cx[b] = rotate_round(cx[b-1] * cos_q - cy[b-1] * sin_q);
                cy[b] = rotate_round(cx[b-1] * sin_q + cy[b-1] * cos_q);
                cz[b] = cz[0];
            end
            for (b = 0; b < n; b++) begin
                nb = (b + 1 < n) ? b + 1 : 0;
                nx = 0; ny = 0; nz = 0;
                if (seen != 0) begin
                    x1 = 64'(prev_ring[b].x);  y1 = 64'(prev_ring[b].y);
                    z1 = 64'(prev_ring[b].z);
                    x4 = 64'(prev_ring[nb].x); y4 = 64'(prev_ring[nb].y);
                    z4 = 64'(prev_ring[nb].z);
                    x3 = cx[nb]; y3 = cy[nb]; z3 = cz[nb];
                    if (seen == 1)
                        neg_cross(cx[b] - x1, cy[b] - y1, cz[b] - z1,
                                  x3 - x1, y3 - y1, z3 - z1, nx, ny, nz);
                    else
                        neg_cross(x4 - x3, y4 - y3, z4 - z3,
                                  x1 - x3, y1 - y3, z1 - z3, nx, ny, nz);
                end
                o.vertex_x = 24'(cx[b]);
                o.vertex_y = 24'(cy[b]);
                o.vertex_z = 24'(cz[b]);
                o.column = 6'(b);
                o.normal_x = 48'(nx);
                o.normal_y = 48'(ny);
                o.normal_z = 48'(nz);
                o.normal_valid = seen != 0;
                o.last_in_ring = b + 1 == n;
                expected_beats.push_back(o);
            end
            for (b = 0; b < n; b++) begin
                prev_ring[b].x = 24'(cx[b]);
                prev_ring[b].y = 24'(cy[b]);
                prev_ring[b].z = 24'(cz[b]);
            end
            rows_seen = seen < 2 ? seen + 1 : 2;
        endfunction

        function void compare(string field, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s expected %0d got %0d", field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(rmg_pkg::t_out got);
            rmg_pkg::t_out e;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat at column %0d", got.column);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            compare("vertex_x", e.vertex_x, got.vertex_x);
            compare("vertex_y", e.vertex_y, got.vertex_y);
            compare("vertex_z", e.vertex_z, got.vertex_z);
            compare("column", e.column, got.column);
            compare("normal_x", e.normal_x, got.normal_x);
            compare("normal_y", e.normal_y, got.normal_y);
            compare("normal_z", e.normal_z, got.normal_z);
            compare("normal_valid", e.normal_valid, got.normal_valid);
            compare("last_in_ring", e.last_in_ring, got.last_in_ring);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rmg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rmg_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    rmg_pkg::t_in                   i_in_data;
    logic                           o_out_valid;
    logic                           i_out_ready;
    rmg_pkg::t_out                  o_out_data;

    ring_scoreboard sb = new();
    int unsigned    burst_left;
    int unsigned    stall_mode;
    int unsigned    stall_count;

    revolution_mesh_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end

    // receiver: switch between always ready, mostly ready and mostly stalled
    initial begin
        i_out_ready = 1'b0;
        stall_mode = 0;
        stall_count = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat(o_out_data);
        if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_count = $urandom_range(20, 300);
        end else begin
            stall_count--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= $urandom_range(0, 9) < 7;
            default: i_out_ready <= $urandom_range(0, 9) < 2;
        endcase
    end

    // hold the write until taken; the caller drops valid after the last one
    task write_reg(logic [rmg_pkg::CFG_IDX_W-1:0] idx, logic [rmg_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task send_point(rmg_pkg::t_in pt);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= pt;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_point(pt);
    endtask

    // drain, then let any ignored point clear the sequencer
    task wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task set_ring(int unsigned steps, logic [15:0] c, logic [15:0] s);
        wait_idle();
        write_reg(rmg_pkg::CFG_RING_STEPS, 16'(steps));
        write_reg(rmg_pkg::CFG_COS_STEP, c);
        write_reg(rmg_pkg::CFG_SIN_STEP, s);
        i_cfg_valid <= 1'b0;
    endtask

    function rmg_pkg::t_in random_point(bit first);
        rmg_pkg::t_in p;
        if ($urandom_range(0, 1)) begin
            p.profile_radius = 24'($urandom);
            p.profile_height = 24'($urandom);
        end else begin
            p.profile_radius = 24'($signed(24'($urandom_range(0, 8191))) - 4096);
            p.profile_height = 24'($signed(24'($urandom_range(0, 8191))) - 4096);
        end
        p.new_profile = first || ($urandom_range(0, 9) == 0);
        return p;
    endfunction

    task run_phase(int unsigned steps, logic [15:0] c, logic [15:0] s, int unsigned count);
        int unsigned k;
        set_ring(steps, c, s);
        for (k = 0; k < count; k++) send_point(random_point(k == 0));
    endtask

    initial begin
        rmg_pkg::t_in p;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, fresh profile and continued rows
        p = '{24'sh7FFFFF, 24'sh7FFFFF, 1'b0}; send_point(p);
        p = '{24'sh800000, 24'sh800000, 1'b0}; send_point(p);
        p = '{24'sh000000, 24'sh7FFFFF, 1'b0}; send_point(p);
        p = '{24'sh7FFFFF, 24'sh800000, 1'b1}; send_point(p);
        p = '{24'sh000100, 24'sh000000, 1'b0}; send_point(p);
        p = '{24'shFFFFFF, 24'sh000100, 1'b0}; send_point(p);

        run_phase(3, -16'sd8192, 16'sd14189, 20);
        run_phase(4, 16'sd0, 16'sd16384, 15);
        run_phase(1, 16'sd16384, 16'sd0, 6);
        run_phase(2, -16'sd16384, 16'sd0, 6);
        // ring size zero: points are dropped without a beat
        run_phase(0, 16'sd16069, 16'sd3196, 4);
        run_phase(127, 16'sd16364, 16'sd804, 4);
        run_phase(64, 16'h8000, 16'h7FFF, 3);
        run_phase(5, 16'($urandom), 16'($urandom), 20);
        run_phase(8, 16'($urandom), 16'($urandom), 30);
        run_phase(6, 16'sd11585, 16'sd11585, 15);

        wait_idle();
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
